[rtl/lj_pair_energy_accumulator_unit_assert.svh]
// Assertion macros shared by the checker of the pair energy accumulator.
// No dependencies; include with the bare file name.
`ifndef LJ_PAIR_ENERGY_ACCUMULATOR_UNIT_ASSERT_SVH
`define LJ_PAIR_ENERGY_ACCUMULATOR_UNIT_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define LJ_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LJ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ljpe_pkg.sv]
// Types, constants and helpers for the Lennard-Jones pair energy accumulator.
// No dependencies.
package ljpe_pkg;

	localparam int IN_DATA_W = 208;
	localparam int D2_W      = 50;
	localparam int SSQ_W     = 34;
	localparam int NUM_W     = 58;

	localparam logic [48:0] ONE_Q24   = 49'(1) << 24;
	localparam logic [63:0] TWO_Q24   = 64'(1) << 25;
	localparam logic [63:0] CAP_MID   = 64'(1) << 62;
	localparam logic [63:0] CAP_E     = 64'(1) << 48;
	localparam logic [47:0] E_MAX     = {1'b0, {47{1'b1}}};
	localparam logic [47:0] E_MIN     = {1'b1, {47{1'b0}}};

	typedef enum logic [2:0] {
		PC_UNREL   = 3'd0,
		PC_BOND    = 3'd1,
		PC_ANGLE   = 3'd2,
		PC_TORSION = 3'd3,
		PC_SKIP    = 3'd4
	} pair_class_t;

	typedef enum logic [2:0] {
		CR_NEAR_CUT  = 3'd0,
		CR_FAR_CUT   = 3'd1,
		CR_NEAR_E    = 3'd2,
		CR_SCALE_14  = 3'd3,
		CR_BOND_LIM  = 3'd4,
		CR_ANGLE_LIM = 3'd5,
		CR_TORS_LIM  = 3'd6,
		CR_HALVE     = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PK_NONE,
		PK_NEAR,
		PK_LJ
	} pair_kind_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_DIV,
		BS_MUL,
		BS_SCALE,
		BS_ACC
	} back_state_t;

	typedef struct packed {
		logic [47:0]        near_cut_sq;
		logic [47:0]        far_cut_sq;
		logic signed [31:0] near_energy;
		logic [16:0]        scale_14;
		logic [47:0]        bond_lim_sq;
		logic [47:0]        angle_lim_sq;
		logic [47:0]        tors_lim_sq;
		logic               halve;
	} ljpe_cfg_t;

	typedef struct packed {
		pair_kind_t        kind;
		logic              scale;
		logic              last;
		logic [D2_W-1:0]   d2;
		logic [SSQ_W-1:0]  s_sq;
		logic [31:0]       dep_prod;
	} pair_job_t;

	typedef struct packed {
		logic [47:0] value;
		logic        ovf;
	} clip_t;

	// Clip a sign and magnitude to the 48-bit signed range.
	function automatic clip_t clip48(input logic neg, input logic [48:0] mag);
		clip_t c;
		c.ovf = 1'b0;
		if (!neg) begin
			if (mag > {1'b0, E_MAX}) begin
				c.value = E_MAX;
				c.ovf   = 1'b1;
			end else begin
				c.value = mag[47:0];
			end
		end else begin
			if (mag > {1'b0, E_MIN}) begin
				c.value = E_MIN;
				c.ovf   = 1'b1;
			end else begin
				c.value = 48'd0 - mag[47:0];
			end
		end
		return c;
	endfunction

endpackage

[rtl/ljpe_mul.sv]
// Multi-cycle 64x64 multiply with right shift and saturation on a 32x32 multiplier.
// Depends on ljpe_pkg.
module ljpe_mul import ljpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic        sh16,
	input  logic        cap48,
	output logic        done,
	output logic [63:0] result
);

	logic         busy_q;
	logic [2:0]   cnt_q;
	logic [63:0]  p_s1;
	logic [1:0]   pidx_s1;
	logic [127:0] acc_q;
	logic [127:0] pp;
	logic [31:0]  a_half, b_half;
	logic [63:0]  cap, r;
	logic         hi_ovf;
	logic [63:0]  fin;

	assign a_half = cnt_q[1] ? a[63:32] : a[31:0];
	assign b_half = cnt_q[0] ? b[63:32] : b[31:0];

	always_comb begin
		case (pidx_s1)
			2'd0:    pp = {64'd0, p_s1};
			2'd3:    pp = {p_s1, 64'd0};
			default: pp = {32'd0, p_s1, 32'd0};
		endcase
		cap = cap48 ? CAP_E : CAP_MID;
		if (sh16) begin
			hi_ovf = |acc_q[127:80];
			r      = acc_q[79:16];
		end else begin
			hi_ovf = |acc_q[127:88];
			r      = acc_q[87:24];
		end
		fin = (hi_ovf || r > cap) ? cap : r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q <= 3'd3) begin
				p_s1    <= a_half * b_half;
				pidx_s1 <= cnt_q[1:0];
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4)
				acc_q <= acc_q + pp;
			if (cnt_q == 3'd5)
				result <= fin;
		end
	end

endmodule

[rtl/ljpe_div.sv]
// Restoring divider (one quotient bit a cycle) with a digit-by-digit square root beside it.
// Depends on ljpe_pkg.
module ljpe_div import ljpe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [D2_W-1:0]  den,
	input  logic [31:0]      rad,
	output logic             done,
	output logic [NUM_W-1:0] quot,
	output logic [15:0]      root
);

	logic             busy_q;
	logic [5:0]       cnt_q;
	logic [D2_W-1:0]  rem_q;
	logic [NUM_W-1:0] n_q;
	logic [31:0]      v_q, r_q, bit_q;
	logic [D2_W:0]    trial;
	logic             ge;
	logic [31:0]      rb;

	assign trial = {rem_q, n_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den};
	assign rb    = r_q + bit_q;
	assign quot  = n_q;
	assign root  = r_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 6'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			n_q   <= num;
			v_q   <= rad;
			r_q   <= '0;
			bit_q <= 32'(1) << 30;
		end else if (busy_q) begin
			rem_q <= ge ? D2_W'(trial - {1'b0, den}) : trial[D2_W-1:0];
			n_q   <= {n_q[NUM_W-2:0], ge};
			if (bit_q != '0) begin
				if (v_q >= rb) begin
					v_q <= v_q - rb;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end

endmodule

[rtl/ljpe_queue.sv]
// Short job queue between the front classifier and the energy back end.
// Depends on ljpe_pkg.
module ljpe_queue import ljpe_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pair_job_t push_job,
	output logic      full,
	input  logic      pop,
	output logic      pop_valid,
	output pair_job_t pop_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pair_job_t      mem_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;

	assign full      = cnt_q == CW'(DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_job   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

endmodule

[rtl/ljpe_front.sv]
// Front end: three-stage pipeline forming the squared distance and classifying each pair.
// Depends on ljpe_pkg.
module ljpe_front import ljpe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ljpe_cfg_t            cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [IN_DATA_W-1:0] in_data,
	input  logic [2:0]           in_class,
	input  logic                 in_last,
	output logic                 job_push,
	output pair_job_t            job,
	input  logic                 job_full
);

	logic               v1_s1, v2_s2, v3_s3, en;
	logic signed [24:0] dx_s1, dy_s1, dz_s1;
	logic [16:0]        ssum_s1;
	logic [15:0]        dep1_s1, dep2_s1;
	logic [2:0]         cls_s1, cls_s2, cls_s3;
	logic               last_s1, last_s2, last_s3;
	logic [48:0]        sqx_s2, sqy_s2, sqz_s2;
	logic [SSQ_W-1:0]   ssq_s2, ssq_s3;
	logic [31:0]        dp_s2, dp_s3;
	logic [D2_W-1:0]    d2_s3;
	logic signed [49:0] px, py, pz;
	logic [D2_W-1:0]    d2w;
	logic               use_p, excl;

	assign en       = !v3_s3 || !job_full;
	assign in_ready = en;
	assign job_push = v3_s3 && !job_full;

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pz = dz_s1 * dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else if (en) begin
			v1_s1 <= in_valid;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= $signed({in_data[23], in_data[23:0]})
				- $signed({in_data[95], in_data[95:72]});
			dy_s1   <= $signed({in_data[47], in_data[47:24]})
				- $signed({in_data[119], in_data[119:96]});
			dz_s1   <= $signed({in_data[71], in_data[71:48]})
				- $signed({in_data[143], in_data[143:120]});
			ssum_s1 <= 17'(in_data[159:144]) + 17'(in_data[191:176]);
			dep1_s1 <= in_data[175:160];
			dep2_s1 <= in_data[207:192];
			cls_s1  <= in_class;
			last_s1 <= in_last;

			sqx_s2  <= px[48:0];
			sqy_s2  <= py[48:0];
			sqz_s2  <= pz[48:0];
			ssq_s2  <= ssum_s1 * ssum_s1;
			dp_s2   <= dep1_s1 * dep2_s1;
			cls_s2  <= cls_s1;
			last_s2 <= last_s1;

			d2_s3   <= D2_W'(sqx_s2) + D2_W'(sqy_s2) + D2_W'(sqz_s2);
			ssq_s3  <= ssq_s2;
			dp_s3   <= dp_s2;
			cls_s3  <= cls_s2;
			last_s3 <= last_s2;
		end
	end

	// Classify: drop skipped, far and excluded 1-2 / 1-3 pairs.
	always_comb begin
		d2w   = d2_s3;
		excl  = (cls_s3 == PC_BOND && d2w <= D2_W'(cfg.bond_lim_sq) + D2_W'(ONE_Q24))
			|| (cls_s3 == PC_ANGLE && d2w <= D2_W'(cfg.angle_lim_sq) + D2_W'(ONE_Q24));
		use_p = (cls_s3 <= PC_TORSION) && (d2w < D2_W'(cfg.far_cut_sq)) && !excl;
		job.kind     = !use_p ? PK_NONE : ((d2w < D2_W'(cfg.near_cut_sq)) ? PK_NEAR : PK_LJ);
		job.scale    = (cls_s3 == PC_TORSION)
			&& (d2w <= D2_W'(cfg.tors_lim_sq) + D2_W'(ONE_Q24));
		job.last     = last_s3;
		job.d2       = d2_s3;
		job.s_sq     = ssq_s3;
		job.dep_prod = dp_s3;
	end

endmodule

[rtl/ljpe_back.sv]
// Back end: sequencer for the 12-6 energy, 1-4 scaling, saturating sum and result register.
// Depends on ljpe_pkg, ljpe_mul and ljpe_div.
module ljpe_back import ljpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ljpe_cfg_t   cfg,
	input  logic        job_valid,
	input  pair_job_t   job,
	output logic        job_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [47:0] out_energy,
	output logic        out_sat
);

	back_state_t state_q, state_d;
	pair_job_t   cur_q;
	logic [1:0]  step_q, step_d;
	logic [63:0] t_q, t_d;
	logic [15:0] eps_q;
	logic        neg_q, neg_d;
	logic [47:0] e_q, e_d, sum_q;
	logic        ovf_q, ovf_set, e_load, t_load, emit, acc_en;
	logic        mul_go, mul_start_q, mul_done;
	logic [63:0] mul_a_q, mul_b_q, mul_a_d, mul_b_d, mul_res;
	logic        mul_sh16_q, mul_cap48_q, mul_sh16_d, mul_cap48_d;
	logic        div_go, div_start_q, div_done;
	logic [NUM_W-1:0] quot;
	logic [15:0] root;
	logic        out_valid_q, emit_ok;
	logic [47:0] near_ext, near_abs, clip_abs, sat_sum;
	logic [48:0] s49;
	logic        sat_ovf;
	clip_t       clip_r;

	ljpe_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q), .a(mul_a_q), .b(mul_b_q),
		.sh16(mul_sh16_q), .cap48(mul_cap48_q), .done(mul_done), .result(mul_res)
	);

	ljpe_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .num({cur_q.s_sq, 24'd0}),
		.den(cur_q.d2), .rad(cur_q.dep_prod), .done(div_done), .quot(quot), .root(root)
	);

	assign out_valid = out_valid_q;
	assign emit_ok   = !out_valid_q || out_ready;
	assign near_ext  = {{16{cfg.near_energy[31]}}, cfg.near_energy};
	assign near_abs  = near_ext[47] ? 48'd0 - near_ext : near_ext;
	assign clip_r    = clip48(neg_q, mul_res[48:0]);
	assign clip_abs  = clip_r.value[47] ? 48'd0 - clip_r.value : clip_r.value;
	assign s49       = {sum_q[47], sum_q} + {e_q[47], e_q};
	assign sat_ovf   = s49[48] ^ s49[47];
	assign sat_sum   = sat_ovf ? (s49[48] ? E_MIN : E_MAX) : s49[47:0];

	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		job_pop     = 1'b0;
		mul_go      = 1'b0;
		mul_a_d     = '0;
		mul_b_d     = '0;
		mul_sh16_d  = 1'b0;
		mul_cap48_d = 1'b0;
		div_go      = 1'b0;
		e_load      = 1'b0;
		e_d         = '0;
		neg_d       = neg_q;
		ovf_set     = 1'b0;
		t_load      = 1'b0;
		t_d         = (cur_q.d2 == '0) ? CAP_MID : 64'(quot);
		emit        = 1'b0;
		acc_en      = 1'b0;
		case (state_q)
			BS_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					case (job.kind)
						PK_LJ: begin
							div_go  = 1'b1;
							state_d = BS_DIV;
						end
						PK_NEAR: begin
							e_load = 1'b1;
							e_d    = near_ext;
							neg_d  = near_ext[47];
							if (job.scale) begin
								mul_go      = 1'b1;
								mul_a_d     = 64'(near_abs);
								mul_b_d     = 64'(cfg.scale_14);
								mul_sh16_d  = 1'b1;
								mul_cap48_d = 1'b1;
								state_d     = BS_SCALE;
							end else begin
								state_d = BS_ACC;
							end
						end
						default: begin
							e_load  = 1'b1;
							neg_d   = 1'b0;
							state_d = BS_ACC;
						end
					endcase
				end
			end
			BS_DIV: begin
				if (div_done) begin
					t_load  = 1'b1;
					mul_go  = 1'b1;
					mul_a_d = t_d;
					mul_b_d = t_d;
					step_d  = 2'd0;
					state_d = BS_MUL;
				end
			end
			BS_MUL: begin
				if (mul_done) begin
					case (step_q)
						2'd0: begin
							mul_go  = 1'b1;
							mul_a_d = mul_res;
							mul_b_d = t_q;
							step_d  = 2'd1;
						end
						2'd1: begin
							neg_d   = mul_res < TWO_Q24;
							mul_go  = 1'b1;
							mul_a_d = mul_res;
							mul_b_d = (mul_res < TWO_Q24) ? TWO_Q24 - mul_res
								: mul_res - TWO_Q24;
							step_d  = 2'd2;
						end
						2'd2: begin
							mul_go      = 1'b1;
							mul_a_d     = 64'(eps_q);
							mul_b_d     = mul_res;
							mul_cap48_d = 1'b1;
							step_d      = 2'd3;
						end
						default: begin
							e_load  = 1'b1;
							e_d     = clip_r.value;
							ovf_set = clip_r.ovf;
							neg_d   = clip_r.value[47];
							if (cur_q.scale) begin
								mul_go      = 1'b1;
								mul_a_d     = 64'(clip_abs);
								mul_b_d     = 64'(cfg.scale_14);
								mul_sh16_d  = 1'b1;
								mul_cap48_d = 1'b1;
								state_d     = BS_SCALE;
							end else begin
								state_d = BS_ACC;
							end
						end
					endcase
				end
			end
			BS_SCALE: begin
				if (mul_done) begin
					e_load  = 1'b1;
					e_d     = clip_r.value;
					ovf_set = clip_r.ovf;
					state_d = BS_ACC;
				end
			end
			BS_ACC: begin
				if (!cur_q.last) begin
					acc_en  = 1'b1;
					state_d = BS_IDLE;
				end else if (emit_ok) begin
					emit    = 1'b1;
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_IDLE;
			step_q      <= '0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			mul_start_q <= mul_go;
			div_start_q <= div_go;
			if (emit) begin
				sum_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				if (acc_en)
					sum_q <= sat_sum;
				ovf_q <= ovf_q | ovf_set | (acc_en & sat_ovf);
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop)
			cur_q <= job;
		if (t_load) begin
			t_q   <= t_d;
			eps_q <= root;
		end
		neg_q <= neg_d;
		if (e_load)
			e_q <= e_d;
		if (mul_go) begin
			mul_a_q     <= mul_a_d;
			mul_b_q     <= mul_b_d;
			mul_sh16_q  <= mul_sh16_d;
			mul_cap48_q <= mul_cap48_d;
		end
		if (emit) begin
			// Halving rounds toward minus infinity: an arithmetic shift.
			out_energy <= cfg.halve ? {sat_sum[47], sat_sum[47:1]} : sat_sum;
			out_sat    <= ovf_q | sat_ovf;
		end
	end

endmodule

[rtl/lj_pair_energy_accumulator_unit.sv]
// Top level of the Lennard-Jones 12-6 pair energy accumulator: register file and wiring.
// Depends on ljpe_pkg, ljpe_front, ljpe_queue and ljpe_back.
//
//   channel   direction  handshake                 payload
//   s_*       in         s_tvalid / s_tready       tdata 208b coords+radii+depths,
//                                                  tuser pair_class, tlast last_pair
//   m_*       out        m_tvalid / m_tready       tdata 48b energy_total, tuser saturated
//   APB       in/out     psel,penable,pwrite       paddr 6b (8-byte steps), pwdata/prdata 64b
//
// The front pipeline takes one pair a cycle unless the job queue is full, and parks
// classified jobs in a small queue. The back end handles one job at a time: a skipped,
// ignored or unscaled near pair is popped and accumulated; a full 12-6 pair first runs
// the one-bit-a-cycle divider with the square root running beside it, then makes four
// passes through the shared 32x32 multiplier before it is accumulated, with one more
// pass when 1-4 scaling applies.
// Reset clears the pipeline, queue, sum, flags and loads the register defaults.
// A stalled result register does not stop the back end unless it must emit again.
module lj_pair_energy_accumulator_unit import ljpe_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z (24b each),
	// first_radius, first_depth, second_radius, second_depth (16b each)
	input  logic [IN_DATA_W-1:0] s_tdata,
	// pair_class
	input  logic [2:0]           s_tuser,
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// energy_total
	output logic [47:0]          m_tdata,
	// saturated
	output logic [0:0]           m_tuser,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [5:0]           paddr,
	input  logic [63:0]          pwdata,
	output logic [63:0]          prdata,
	output logic                 pready
);

	ljpe_cfg_t cfg_q;
	logic      wr_en;
	cfg_idx_t  widx;
	logic      push, full, pop, pop_valid;
	pair_job_t push_job, pop_job;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign widx   = cfg_idx_t'(paddr[5:3]);

	// Register file; the low address bits are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_cut_sq  <= '0;
			cfg_q.far_cut_sq   <= '0;
			cfg_q.near_energy  <= '0;
			cfg_q.scale_14     <= 17'd65536;
			cfg_q.bond_lim_sq  <= '0;
			cfg_q.angle_lim_sq <= '0;
			cfg_q.tors_lim_sq  <= '0;
			cfg_q.halve        <= 1'b0;
		end else if (wr_en) begin
			case (widx)
				CR_NEAR_CUT:  cfg_q.near_cut_sq  <= pwdata[47:0];
				CR_FAR_CUT:   cfg_q.far_cut_sq   <= pwdata[47:0];
				CR_NEAR_E:    cfg_q.near_energy  <= pwdata[31:0];
				CR_SCALE_14:  cfg_q.scale_14     <= pwdata[16:0];
				CR_BOND_LIM:  cfg_q.bond_lim_sq  <= pwdata[47:0];
				CR_ANGLE_LIM: cfg_q.angle_lim_sq <= pwdata[47:0];
				CR_TORS_LIM:  cfg_q.tors_lim_sq  <= pwdata[47:0];
				CR_HALVE:     cfg_q.halve        <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			CR_NEAR_CUT:  prdata = 64'(cfg_q.near_cut_sq);
			CR_FAR_CUT:   prdata = 64'(cfg_q.far_cut_sq);
			CR_NEAR_E:    prdata = {32'd0, cfg_q.near_energy};
			CR_SCALE_14:  prdata = 64'(cfg_q.scale_14);
			CR_BOND_LIM:  prdata = 64'(cfg_q.bond_lim_sq);
			CR_ANGLE_LIM: prdata = 64'(cfg_q.angle_lim_sq);
			CR_TORS_LIM:  prdata = 64'(cfg_q.tors_lim_sq);
			CR_HALVE:     prdata = 64'(cfg_q.halve);
			default:      prdata = '0;
		endcase
	end

	ljpe_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
		.in_class(s_tuser), .in_last(s_tlast),
		.job_push(push), .job(push_job), .job_full(full)
	);

	ljpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job), .full(full),
		.pop(pop), .pop_valid(pop_valid), .pop_job(pop_job)
	);

	ljpe_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.job_valid(pop_valid), .job(pop_job), .job_pop(pop),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_energy(m_tdata), .out_sat(m_tuser[0])
	);

endmodule

[rtl/ljpe_checker.sv]
// Port-level checks for the pair energy accumulator, bound to the top level.
// Depends on ljpe_pkg and lj_pair_energy_accumulator_unit_assert.svh.
`include "lj_pair_energy_accumulator_unit_assert.svh"
module ljpe_checker import ljpe_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic        pready,
	input logic [5:0]  paddr,
	input logic [63:0] pwdata,
	input logic [63:0] prdata
);

	// A stalled result holds.
	`LJ_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// No result shows while reset is asserted.
	`LJ_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !m_tvalid, "result valid during reset")

	// The halve flag reads back as written.
	`LJ_ASSERT_CLK(a_halve_rb, psel && penable && pwrite && pready && paddr[5:3] == CR_HALVE |=> paddr[5:3] != CR_HALVE || prdata[0] == $past(pwdata[0]), "halve register readback mismatch")

endmodule

bind lj_pair_energy_accumulator_unit ljpe_checker u_ljpe_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser), .psel(psel), .penable(penable),
	.pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata), .prdata(prdata)
);

[tb/lj_pair_energy_accumulator_unit_tb.sv]
// Self-checking testbench for the Lennard-Jones pair energy accumulator.
// Depends on ljpe_pkg and lj_pair_energy_accumulator_unit; drives the streams and the APB port.
module lj_pair_energy_accumulator_unit_tb;
	import ljpe_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 200;
	localparam int RANDOM_PHASES  = 8;
	localparam int PAIRS_PER_PHASE = 75;
	localparam bit [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;
	localparam bit [63:0] Q24_ONE = 64'd1 << 24;

	// One atom pair as it travels on the input stream.
	typedef struct {
		logic signed [23:0] ax, ay, az, bx, by, bz;
		logic [15:0]        rad_a, dep_a, rad_b, dep_b;
		logic [2:0]         cls;
		logic               last;
	} atom_pair_t;

	// Energy predictor and store of expected totals.
	class pair_energy_board;
		bit [47:0]        near_cut, far_cut, bond_lim, angle_lim, tors_lim;
		bit signed [31:0] near_e;
		bit [16:0]        scale;
		bit               halve;
		longint           run_sum;
		bit               run_ovf;
		bit [47:0]        total_q[$];
		bit               sat_q[$];
		int               mismatches, totals_checked, pairs_taken;

		function new();
			near_cut = 0; far_cut = 0; near_e = 0; scale = 17'd65536;
			bond_lim = 0; angle_lim = 0; tors_lim = 0; halve = 0;
			run_sum = 0; run_ovf = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, bit [63:0] v);
			case (idx)
				CR_NEAR_CUT:  near_cut  = v[47:0];
				CR_FAR_CUT:   far_cut   = v[47:0];
				CR_NEAR_E:    near_e    = v[31:0];
				CR_SCALE_14:  scale     = v[16:0];
				CR_BOND_LIM:  bond_lim  = v[47:0];
				CR_ANGLE_LIM: angle_lim = v[47:0];
				CR_TORS_LIM:  tors_lim  = v[47:0];
				CR_HALVE:     halve     = v[0];
				default: ;
			endcase
		endfunction

		// floor(a*b / 2^sh), capped
		function bit [63:0] mul_trunc(bit [63:0] a, bit [63:0] b, int sh, bit [63:0] cap);
			bit [127:0] p;
			p = ({64'd0, a} * {64'd0, b}) >> sh;
			return (p > {64'd0, cap}) ? cap : p[63:0];
		endfunction

		function bit [63:0] root32(bit [63:0] v);
			bit [63:0] r, cand;
			r = 0;
			for (int b = 16; b >= 0; b--) begin
				cand = r | (64'd1 << b);
				if (cand * cand <= v)
					r = cand;
			end
			return r;
		endfunction

		function longint clamp48(bit neg, bit [63:0] mag);
			if (!neg) begin
				if (mag > {16'd0, E_MAX}) begin
					run_ovf = 1;
					return longint'({16'd0, E_MAX});
				end
				return longint'(mag);
			end
			if (mag > {16'd0, E_MIN}) begin
				run_ovf = 1;
				mag = {16'd0, E_MIN};
			end
			return -longint'(mag);
		endfunction

		function longint lj_pair(bit [63:0] d2, atom_pair_t p);
			bit [63:0] s, eps, t, u, r6, diff, m, mag;
			bit neg;
			s   = 64'(p.rad_a) + 64'(p.rad_b);
			eps = root32(64'(p.dep_a) * 64'(p.dep_b));
			t   = (d2 == 0) ? CAP_MID : ((s * s) << 24) / d2;
			if (t > CAP_MID)
				t = CAP_MID;
			u    = mul_trunc(t, t, 24, CAP_MID);
			r6   = mul_trunc(u, t, 24, CAP_MID);
			neg  = r6 < TWO_Q24;
			diff = neg ? TWO_Q24 - r6 : r6 - TWO_Q24;
			m    = mul_trunc(r6, diff, 24, CAP_MID);
			mag  = mul_trunc(eps, m, 24, CAP_E);
			return clamp48(neg, mag);
		endfunction

		function void note_pair(atom_pair_t p);
			longint dx, dy, dz, e, sum;
			bit [63:0] d2, mag;
			bit use_it, neg;
			pairs_taken++;
			if (p.cls <= PC_TORSION) begin
				dx = longint'(p.ax) - longint'(p.bx);
				dy = longint'(p.ay) - longint'(p.by);
				dz = longint'(p.az) - longint'(p.bz);
				d2 = dx * dx + dy * dy + dz * dz;
				use_it = d2 < far_cut;
				if (p.cls == PC_BOND && d2 <= bond_lim + Q24_ONE)
					use_it = 0;
				if (p.cls == PC_ANGLE && d2 <= angle_lim + Q24_ONE)
					use_it = 0;
				if (use_it) begin
					e = (d2 < near_cut) ? longint'(near_e) : lj_pair(d2, p);
					if (p.cls == PC_TORSION && d2 <= tors_lim + Q24_ONE) begin
						neg = e < 0;
						mag = neg ? -e : e;
						e = clamp48(neg, mul_trunc(mag, 64'(scale), 16, CAP_E));
					end
					sum = run_sum + e;
					if (sum > longint'({16'd0, E_MAX})) begin
						sum = longint'({16'd0, E_MAX});
						run_ovf = 1;
					end else if (sum < -longint'({16'd0, E_MIN})) begin
						sum = -longint'({16'd0, E_MIN});
						run_ovf = 1;
					end
					run_sum = sum;
				end
			end
			if (p.last) begin
				sum = halve ? (run_sum >>> 1) : run_sum;
				total_q.push_back(sum[47:0]);
				sat_q.push_back(run_ovf);
				run_sum = 0;
				run_ovf = 0;
			end
		endfunction

		function void check_total(bit [47:0] tot, bit sat);
			bit [47:0] want_tot;
			bit want_sat;
			if (total_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: total %h sat %0b with nothing expected", tot, sat);
				return;
			end
			want_tot = total_q.pop_front();
			want_sat = sat_q.pop_front();
			totals_checked++;
			if (tot !== want_tot || sat !== want_sat) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: total exp %h got %h, sat exp %0b got %0b",
						want_tot, tot, want_sat, sat);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata  = '0;
	logic [2:0]           s_tuser  = '0;
	logic                 s_tlast  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [47:0]          m_tdata;
	logic [0:0]           m_tuser;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [5:0]           paddr    = '0;
	logic [63:0]          pwdata   = '0;
	logic [63:0]          prdata;
	logic                 pready;

	pair_energy_board board;
	int idle_cycles = 0;
	int cycle_count = 0;
	int burst_left  = 0;

	lj_pair_energy_accumulator_unit dut (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Output side: check each transfer against the oldest expected total, then pick
	// the next ready value. The stall mode rotates so some stretches never stall.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (m_tvalid && m_tready)
			board.check_total(m_tdata, m_tuser[0]);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		case ((cycle_count / 700) % 3)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 9) < 7);
			default: m_tready <= ((cycle_count % 29) > 11);
		endcase
	end

	// Watchdog: nothing moved on either stream for too long.
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("lj_pair_energy_accumulator_unit regression: fail");
		$finish;
	end

	// Setup cycle, then access cycle; the register takes the value at the access edge.
	task automatic write_reg(cfg_idx_t idx, bit [63:0] v);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 3'b000};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.set_reg(idx, v);
	endtask

	task automatic load_regs(bit [63:0] nc, bit [63:0] fc, bit [63:0] ne, bit [63:0] sc,
			bit [63:0] bl, bit [63:0] al, bit [63:0] tl, bit [63:0] hv);
		write_reg(CR_NEAR_CUT, nc);
		write_reg(CR_FAR_CUT, fc);
		write_reg(CR_NEAR_E, ne);
		write_reg(CR_SCALE_14, sc);
		write_reg(CR_BOND_LIM, bl);
		write_reg(CR_ANGLE_LIM, al);
		write_reg(CR_TORS_LIM, tl);
		write_reg(CR_HALVE, hv);
	endtask

	// Hold the pair until its transfer, then note it and maybe drop valid for a gap.
	task automatic send_pair(atom_pair_t p);
		s_tdata  <= {p.dep_b, p.rad_b, p.dep_a, p.rad_a, p.bz, p.by, p.bx, p.az, p.ay, p.ax};
		s_tuser  <= p.cls;
		s_tlast  <= p.last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_pair(p);
		if (burst_left == 0) begin
			burst_left = $urandom_range(0, 20);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Drain every expected total, then let the back end finish pairs with no result.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.total_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Pair along the x axis at a given Q12 separation, radii 1.5 A each.
	function automatic atom_pair_t on_axis(int sep, logic [2:0] cls, logic last);
		atom_pair_t p;
		p.ax = 0; p.ay = 0; p.az = 0;
		p.bx = 24'(sep); p.by = 0; p.bz = 0;
		p.rad_a = 16'd6144; p.rad_b = 16'd6144;
		p.dep_a = 16'h8000; p.dep_b = 16'h8000;
		p.cls = cls;
		p.last = last;
		return p;
	endfunction

	function automatic atom_pair_t random_pair(logic last);
		atom_pair_t p;
		int cx, cy, cz;
		cx = int'($urandom_range(0, 16000000)) - 8000000;
		cy = int'($urandom_range(0, 16000000)) - 8000000;
		cz = int'($urandom_range(0, 16000000)) - 8000000;
		p.ax = 24'(cx); p.ay = 24'(cy); p.az = 24'(cz);
		// mostly neighbors within a few angstrom, sometimes anywhere at all
		if ($urandom_range(0, 6) == 0) begin
			p.bx = 24'($urandom); p.by = 24'($urandom); p.bz = 24'($urandom);
		end else begin
			p.bx = 24'(cx + int'($urandom_range(0, 49152)) - 24576);
			p.by = 24'(cy + int'($urandom_range(0, 49152)) - 24576);
			p.bz = 24'(cz + int'($urandom_range(0, 49152)) - 24576);
		end
		if ($urandom_range(0, 9) == 0) begin
			p.rad_a = 16'($urandom); p.rad_b = 16'($urandom);
		end else begin
			p.rad_a = 16'($urandom_range(4000, 9000));
			p.rad_b = 16'($urandom_range(4000, 9000));
		end
		p.dep_a = 16'($urandom);
		p.dep_b = 16'($urandom);
		p.cls = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(PC_SKIP, 7))
			: 3'($urandom_range(PC_UNREL, PC_TORSION));
		p.last = last;
		return p;
	endfunction

	function automatic bit [63:0] pick_dist(bit [63:0] lo, bit [63:0] hi);
		case ($urandom_range(0, 3))
			0: return 0;
			1: return MAX48;
			2: return {$urandom, $urandom} & MAX48;
			default: return 64'($urandom_range(32'(lo), 32'(hi)));
		endcase
	endfunction

	initial begin
		atom_pair_t p;
		int set_left;
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: far cutoff zero ignores everything, total comes out zero.
		send_pair(on_axis(2048, PC_UNREL, 1'b0));
		send_pair(on_axis(8192, PC_TORSION, 1'b1));
		settle();

		// Near energy, 1-4 scaling at full scale, exclusions, skips, odd negative halving.
		load_regs(Q24_ONE, MAX48, 64'(-7), 64'h1FFFF, 4 * Q24_ONE, 4 * Q24_ONE,
			4 * Q24_ONE, 1);
		send_pair(on_axis(2048, PC_UNREL, 1'b0));
		send_pair(on_axis(2048, PC_TORSION, 1'b0));
		send_pair(on_axis(8192, PC_BOND, 1'b0));
		send_pair(on_axis(12288, PC_BOND, 1'b0));
		send_pair(on_axis(8192, PC_ANGLE, 1'b0));
		send_pair(on_axis(12288, PC_ANGLE, 1'b0));
		send_pair(on_axis(12288, PC_TORSION, 1'b0));
		send_pair(on_axis(9000, PC_TORSION, 1'b0));
		send_pair(on_axis(4096, PC_SKIP, 1'b0));
		send_pair(on_axis(4096, 3'd5, 1'b0));
		send_pair(on_axis(4096, 3'd6, 1'b0));
		// opposite corners of the coordinate range
		p = on_axis(0, PC_UNREL, 1'b0);
		p.ax = 24'sh800000; p.ay = 24'sh800000; p.az = 24'sh800000;
		p.bx = 24'sh7FFFFF; p.by = 24'sh7FFFFF; p.bz = 24'sh7FFFFF;
		p.rad_a = 16'hFFFF; p.dep_a = 16'hFFFF; p.rad_b = 16'hFFFF; p.dep_b = 16'hFFFF;
		send_pair(p);
		p.ax = 24'sh7FFFFF; p.bx = 24'sh800000;
		send_pair(p);
		send_pair(on_axis(2048, PC_UNREL, 1'b1));
		send_pair(on_axis(4096, PC_SKIP, 1'b1));
		send_pair(on_axis(4096, 3'd7, 1'b1));
		settle();

		// Zero distance saturates, far cutoff edge, zero scale, accumulator clipping.
		load_regs(0, 9 * Q24_ONE, 64'h7FFF_FFFF, 0, 0, 0, MAX48, 0);
		send_pair(on_axis(0, PC_UNREL, 1'b0));
		send_pair(on_axis(0, PC_UNREL, 1'b0));
		send_pair(on_axis(12288, PC_UNREL, 1'b1));
		p = on_axis(0, PC_UNREL, 1'b0);
		p.dep_a = 0;
		send_pair(p);
		send_pair(on_axis(12287, PC_UNREL, 1'b0));
		send_pair(on_axis(4096, PC_TORSION, 1'b1));
		settle();

		// Random phases: new settings each time, sets of random length.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == 0)
				load_regs(MAX48, MAX48, 64'h8000_0000, 64'h1FFFF, MAX48, MAX48, MAX48, 1);
			else if (ph == 1)
				load_regs(0, MAX48, 64'h7FFF_FFFF, 0, 0, 0, 0, 0);
			else
				load_regs(pick_dist(0, 4 * Q24_ONE), pick_dist(16 * Q24_ONE, 100 * Q24_ONE),
					64'($urandom), 64'($urandom_range(0, 17'h1FFFF)),
					pick_dist(Q24_ONE, 9 * Q24_ONE), pick_dist(Q24_ONE, 9 * Q24_ONE),
					pick_dist(Q24_ONE, 9 * Q24_ONE), 64'($urandom_range(0, 1)));
			set_left = $urandom_range(0, 11);
			for (int i = 0; i < PAIRS_PER_PHASE; i++) begin
				send_pair(random_pair(set_left == 0 || i == PAIRS_PER_PHASE - 1));
				set_left = (set_left == 0) ? $urandom_range(0, 11) : set_left - 1;
			end
			settle();
		end

		if (board.total_q.size() != 0) begin
			$display("ERROR: %0d expected totals never arrived", board.total_q.size());
			board.mismatches += board.total_q.size();
		end
		$display("Covered %0d pairs and %0d set totals over %0d register settings.",
			board.pairs_taken, board.totals_checked, RANDOM_PHASES + 3);
		$display("Mismatches counted: %0d", board.mismatches);
		if (board.mismatches == 0)
			$display("lj_pair_energy_accumulator_unit regression: pass");
		else
			$display("lj_pair_energy_accumulator_unit regression: fail");
		$finish;
	end

endmodule
